/* design/cghs_pkg.sv */
`default_nettype none
package cghs_pkg;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPW    = 2;

  // control flags carried with each queued request
  typedef struct packed {
    logic store;  // write the point into the store
    logic last;   // set ends here
    logic ovf;    // points of this set were dropped
  } q_flags_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

/* design/convex_hull_graham_scan_top.sv */
`default_nettype none
// loading: one point request per cycle while the queue has room
// hull: a pivot search, then an insertion sort (n*n/2 comparisons at most) that shifts
//   sorted entries one at a time to open a gap, then a scan of each sorted point with
//   its pops, then the vertices out; the sort runs over the point store memory through
//   one shared multiplier pair
// reset: synchronous active-low rst_n clears front counters, queue and state; memories are not cleared
module convex_hull_graham_scan_top
  import cghs_pkg::*;
#(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_point_x,
  input  wire logic [15:0] in_point_y,
  input  wire logic        in_last_point,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_vertex_x,
  output logic [15:0]      out_vertex_y,
  output logic             out_hull_empty,
  output logic             out_overflow,
  output logic             out_last_vertex
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int EW = IW + NW + 2 * COORD_BITS + 3;

  q_status_t     q_st;
  logic          q_push, q_pop;
  logic [EW-1:0] q_din, q_dout;

  // front: accept and classify requests
  cghs_front #(
    .MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS), .IW(IW), .NW(NW), .EW(EW)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_last_point(in_last_point),
    .q_st(q_st), .q_push(q_push), .q_din(q_din)
  );

  // queue between the two sides
  cghs_queue #(.W(EW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .din(q_din), .pop(q_pop), .dout(q_dout), .st(q_st)
  );

  // back: store, sort, scan and emit
  cghs_back #(
    .MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS), .IW(IW), .NW(NW), .EW(EW)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_dout(q_dout), .q_st(q_st), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y),
    .out_hull_empty(out_hull_empty), .out_overflow(out_overflow),
    .out_last_vertex(out_last_vertex)
  );

  // an empty hull is a single zero result
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hull_empty |->
      out_vertex_x == 16'd0 && out_vertex_y == 16'd0 && out_last_vertex)
    else $error("empty hull result not zero or not last");

  // a full queue holds off the input
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.full |-> in_stall)
    else $error("input taken with queue full");

  // nothing follows the last vertex at once
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_vertex |=> !out_valid)
    else $error("result right after last vertex");

endmodule
`default_nettype wire

/* design/cghs_front.sv */
`default_nettype none
module cghs_front
  import cghs_pkg::*;
#(
  parameter int MAX_POINTS  = 32,
  parameter int COORD_BITS  = 16,
  parameter int IW          = $clog2(MAX_POINTS),
  parameter int NW          = $clog2(MAX_POINTS + 1),
  parameter int EW          = IW + NW + 2 * COORD_BITS + 3
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [15:0]       in_point_x,
  input  wire logic [15:0]       in_point_y,
  input  wire logic              in_last_point,
  input  wire q_status_t         q_st,
  output logic                   q_push,
  output logic [EW-1:0]          q_din
);

  localparam int CW = COORD_BITS;

  logic [NW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          accept;
  logic          room;
  q_flags_t      flags;
  logic [CW+15:0] xz, yz;
  logic [NW-1:0] cnt_out;

  assign in_stall = q_st.full;
  assign accept   = in_valid && !in_stall;
  assign room     = (count_r < NW'(MAX_POINTS));

  // take the low coordinate bits of the request
  assign xz = {{CW{1'b0}}, in_point_x};
  assign yz = {{CW{1'b0}}, in_point_y};

  // classify: store, drop, end of set
  always_comb begin
    flags.store = room;
    flags.last  = in_last_point;
    flags.ovf   = ovf_r || !room;
    cnt_out     = room ? NW'(count_r + 1'b1) : count_r;
    q_push      = accept && (room || in_last_point);
    q_din       = {count_r[IW-1:0], cnt_out, xz[CW-1:0], yz[CW-1:0], flags};
  end

  // point count and overflow mark
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (in_last_point) begin
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end else if (room) begin
        count_nxt = NW'(count_r + 1'b1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/cghs_queue.sv */
`default_nettype none
module cghs_queue
  import cghs_pkg::*;
#(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output q_status_t         st
);

  logic [W-1:0]   mem_r [QDEPTH];
  logic [QPW-1:0] wp_r, rp_r;
  logic [QPW:0]   cnt_r;
  logic           do_push, do_pop;

  assign st.full  = (cnt_r == (QPW + 1)'(QDEPTH));
  assign st.empty = (cnt_r == '0);
  assign do_push  = push && !st.full;
  assign do_pop   = pop && !st.empty;
  assign dout     = mem_r[rp_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= QPW'(wp_r + 1'b1);
      if (do_pop)  rp_r <= QPW'(rp_r + 1'b1);
      if (do_push && !do_pop) cnt_r <= (QPW + 1)'(cnt_r + 1'b1);
      else if (do_pop && !do_push) cnt_r <= (QPW + 1)'(cnt_r - 1'b1);
    end
  end

endmodule
`default_nettype wire

/* design/cghs_back.sv */
`default_nettype none
module cghs_back
  import cghs_pkg::*;
#(
  parameter int MAX_POINTS  = 32,
  parameter int COORD_BITS  = 16,
  parameter int IW          = $clog2(MAX_POINTS),
  parameter int NW          = $clog2(MAX_POINTS + 1),
  parameter int EW          = IW + NW + 2 * COORD_BITS + 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [EW-1:0] q_dout,
  input  wire q_status_t     q_st,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [15:0]        out_vertex_x,
  output logic [15:0]        out_vertex_y,
  output logic               out_hull_empty,
  output logic               out_overflow,
  output logic               out_last_vertex
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int NS = 28;

  typedef enum logic [NS-1:0] {
    S_LOAD   = NS'(1) << 0,  S_PV_RD  = NS'(1) << 1,  S_PV_EV  = NS'(1) << 2,
    S_SI_RD  = NS'(1) << 3,  S_SI_EV  = NS'(1) << 4,  S_SI_M   = NS'(1) << 5,
    S_SI_D   = NS'(1) << 6,  S_SK_RD  = NS'(1) << 7,  S_SK_IX  = NS'(1) << 8,
    S_SK_PT  = NS'(1) << 9,  S_SK_M   = NS'(1) << 10, S_SK_T   = NS'(1) << 11,
    S_SK_M2  = NS'(1) << 12, S_SK_D   = NS'(1) << 13, S_SH     = NS'(1) << 14,
    S_SH_W   = NS'(1) << 15, S_SC0    = NS'(1) << 16, S_SC_RD  = NS'(1) << 17,
    S_SC_IX  = NS'(1) << 18, S_SC_PT  = NS'(1) << 19, S_SC_DF  = NS'(1) << 20,
    S_SC_M   = NS'(1) << 21, S_SC_T   = NS'(1) << 22, S_SC_POP = NS'(1) << 23,
    S_PUSH   = NS'(1) << 24, S_OUT_RD = NS'(1) << 25, S_OUT_W  = NS'(1) << 26,
    S_EMPTY  = NS'(1) << 27
  } state_t;

  state_t state_r, state_nxt;

  // queued request fields
  q_flags_t      e_flags;
  logic [CW-1:0] e_y, e_x;
  logic [NW-1:0] e_cnt;
  logic [IW-1:0] e_addr;

  assign e_flags = q_flags_t'(q_dout[2:0]);
  assign e_y     = q_dout[CW+2:3];
  assign e_x     = q_dout[2*CW+2:CW+3];
  assign e_cnt   = q_dout[2*CW+NW+2:2*CW+3];
  assign e_addr  = q_dout[EW-1:2*CW+NW+3];

  // memories
  logic [2*CW-1:0] pmem [MAX_POINTS];
  logic [IW-1:0]   smem [MAX_POINTS];
  logic [2*CW-1:0] hmem [MAX_POINTS];
  logic [2*CW-1:0] pm_q, hm_q;
  logic [IW-1:0]   sm_q;
  logic            pm_we, sm_we, hm_we;
  logic [IW-1:0]   pm_wa, sm_wa, hm_wa, pm_ra, sm_ra, hm_ra;
  logic [2*CW-1:0] pm_wd, hm_wd;
  logic [IW-1:0]   sm_wd;

  always_ff @(posedge clk) begin
    if (pm_we) pmem[pm_wa] <= pm_wd;
    pm_q <= pmem[pm_ra];
  end

  always_ff @(posedge clk) begin
    if (sm_we) smem[sm_wa] <= sm_wd;
    sm_q <= smem[sm_ra];
  end

  always_ff @(posedge clk) begin
    if (hm_we) hmem[hm_wa] <= hm_wd;
    hm_q <= hmem[hm_ra];
  end

  // counters and working registers
  logic [NW-1:0] n_r, n_nxt, i_r, i_nxt, k_r, k_nxt, j_r, j_nxt;
  logic [NW-1:0] m_r, m_nxt, d_r, d_nxt;
  logic [IW-1:0] piv_r, piv_nxt;
  logic          ovf_r, ovf_nxt;
  logic signed [CW-1:0] px_r, px_nxt, py_r, py_nxt, cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [CW-1:0] t1x_r, t1x_nxt, t1y_r, t1y_nxt, t2x_r, t2x_nxt, t2y_r, t2y_nxt;
  logic signed [DW-1:0] dax_r, dax_nxt, day_r, day_nxt, dbx_r, dbx_nxt, dby_r, dby_nxt;
  logic signed [SW-1:0] d2a_r, d2a_nxt;
  logic signed [PW-1:0] p0_r, p1_r;
  logic signed [DW-1:0] ma0, mb0, ma1, mb1;

  // output register
  logic          ov_r, ov_nxt;
  logic [CW-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic          oe_r, oe_nxt, ol_r, ol_nxt, oo_r, oo_nxt;
  logic          ofree;

  // memory data split into coordinates
  logic signed [CW-1:0] pmx, pmy, hmx, hmy;
  logic signed [SW-1:0] tv, dv;
  logic [CW+15:0]       oxz, oyz;

  assign pmx   = pm_q[2*CW-1:CW];
  assign pmy   = pm_q[CW-1:0];
  assign hmx   = hm_q[2*CW-1:CW];
  assign hmy   = hm_q[CW-1:0];
  assign tv    = $signed({p0_r[PW-1], p0_r}) - $signed({p1_r[PW-1], p1_r});
  assign dv    = $signed({p0_r[PW-1], p0_r}) + $signed({p1_r[PW-1], p1_r});
  assign ofree = !ov_r || !out_stall;

  // shared multiplier pair
  always_comb begin
    case (state_r)
      S_SI_M: begin
        ma0 = dax_r; mb0 = dax_r; ma1 = day_r; mb1 = day_r;
      end
      S_SK_M2: begin
        ma0 = dbx_r; mb0 = dbx_r; ma1 = dby_r; mb1 = dby_r;
      end
      default: begin
        ma0 = dax_r; mb0 = dby_r; ma1 = day_r; mb1 = dbx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p0_r <= ma0 * mb0;
    p1_r <= ma1 * mb1;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; i_nxt = i_r; k_nxt = k_r; j_nxt = j_r; m_nxt = m_r; d_nxt = d_r;
    piv_nxt = piv_r; ovf_nxt = ovf_r;
    px_nxt = px_r; py_nxt = py_r; cx_nxt = cx_r; cy_nxt = cy_r;
    t1x_nxt = t1x_r; t1y_nxt = t1y_r; t2x_nxt = t2x_r; t2y_nxt = t2y_r;
    dax_nxt = dax_r; day_nxt = day_r; dbx_nxt = dbx_r; dby_nxt = dby_r;
    d2a_nxt = d2a_r;
    ov_nxt = ov_r && out_stall;
    ox_nxt = ox_r; oy_nxt = oy_r; oe_nxt = oe_r; ol_nxt = ol_r; oo_nxt = oo_r;
    q_pop = 1'b0;
    pm_we = 1'b0; pm_wa = e_addr; pm_wd = {e_x, e_y};
    sm_we = 1'b0; sm_wa = k_r[IW-1:0]; sm_wd = i_r[IW-1:0];
    hm_we = 1'b0; hm_wa = d_r[IW-1:0]; hm_wd = {cx_r, cy_r};
    pm_ra = i_r[IW-1:0];
    sm_ra = k_r[IW-1:0];
    hm_ra = k_r[IW-1:0];
    oxz = {16'b0, hmx};
    oyz = {16'b0, hmy};

    case (state_r)
      // take stored points until the end of a set
      S_LOAD: begin
        if (!q_st.empty) begin
          q_pop = 1'b1;
          pm_we = e_flags.store;
          if (e_flags.last) begin
            n_nxt   = e_cnt;
            ovf_nxt = e_flags.ovf;
            i_nxt   = '0;
            state_nxt = (e_cnt == '0) ? S_EMPTY : S_PV_RD;
          end
        end
      end

      // pivot search: lowest y, then lowest x
      S_PV_RD: state_nxt = S_PV_EV;
      S_PV_EV: begin
        if (i_r == '0 || pmy < py_r || (pmy == py_r && pmx < px_r)) begin
          piv_nxt = i_r[IW-1:0];
          px_nxt  = pmx;
          py_nxt  = pmy;
        end
        i_nxt = NW'(i_r + 1'b1);
        if (NW'(i_r + 1'b1) == n_r) begin
          i_nxt = '0;
          m_nxt = '0;
          state_nxt = S_SI_RD;
        end else begin
          state_nxt = S_PV_RD;
        end
      end

      // insertion sort: next candidate
      S_SI_RD: begin
        if (i_r == n_r) begin
          state_nxt = S_SC0;
        end else if (i_r[IW-1:0] == piv_r) begin
          i_nxt = NW'(i_r + 1'b1);
        end else begin
          state_nxt = S_SI_EV;
        end
      end
      S_SI_EV: begin
        dax_nxt = {pmx[CW-1], pmx} - {px_r[CW-1], px_r};
        day_nxt = {pmy[CW-1], pmy} - {py_r[CW-1], py_r};
        state_nxt = S_SI_M;
      end
      S_SI_M: state_nxt = S_SI_D;
      S_SI_D: begin
        if (dv == '0) begin
          i_nxt = NW'(i_r + 1'b1);
          state_nxt = S_SI_RD;
        end else begin
          d2a_nxt = dv;
          k_nxt   = '0;
          state_nxt = S_SK_RD;
        end
      end

      // walk the sorted list for the insertion place
      S_SK_RD: begin
        if (k_r == m_r) begin
          j_nxt = m_r;
          state_nxt = S_SH;
        end else begin
          state_nxt = S_SK_IX;
        end
      end
      S_SK_IX: begin
        pm_ra = sm_q;
        state_nxt = S_SK_PT;
      end
      S_SK_PT: begin
        dbx_nxt = {pmx[CW-1], pmx} - {px_r[CW-1], px_r};
        dby_nxt = {pmy[CW-1], pmy} - {py_r[CW-1], py_r};
        state_nxt = S_SK_M;
      end
      S_SK_M: state_nxt = S_SK_T;
      S_SK_T: begin
        if (tv > 0) begin
          j_nxt = m_r;
          state_nxt = S_SH;
        end else if (tv < 0) begin
          k_nxt = NW'(k_r + 1'b1);
          state_nxt = S_SK_RD;
        end else begin
          state_nxt = S_SK_M2;
        end
      end
      S_SK_M2: state_nxt = S_SK_D;
      S_SK_D: begin
        if (d2a_r < dv) begin
          j_nxt = m_r;
          state_nxt = S_SH;
        end else if (dv < d2a_r) begin
          k_nxt = NW'(k_r + 1'b1);
          state_nxt = S_SK_RD;
        end else begin
          // same point as one already sorted
          i_nxt = NW'(i_r + 1'b1);
          state_nxt = S_SI_RD;
        end
      end

      // open a gap at the insertion place, one entry a step
      S_SH: begin
        if (j_r == k_r) begin
          sm_we = 1'b1;
          m_nxt = NW'(m_r + 1'b1);
          i_nxt = NW'(i_r + 1'b1);
          state_nxt = S_SI_RD;
        end else begin
          sm_ra = IW'(j_r - 1'b1);
          state_nxt = S_SH_W;
        end
      end
      S_SH_W: begin
        sm_we = 1'b1;
        sm_wa = j_r[IW-1:0];
        sm_wd = sm_q;
        j_nxt = NW'(j_r - 1'b1);
        state_nxt = S_SH;
      end

      // scan start: pivot on the stack
      S_SC0: begin
        if (m_r == '0) begin
          state_nxt = S_EMPTY;
        end else begin
          hm_we = 1'b1;
          hm_wa = '0;
          hm_wd = {px_r, py_r};
          t1x_nxt = px_r;
          t1y_nxt = py_r;
          d_nxt = NW'(1);
          k_nxt = '0;
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        if (k_r == m_r) begin
          k_nxt = '0;
          state_nxt = S_OUT_RD;
        end else begin
          state_nxt = S_SC_IX;
        end
      end
      S_SC_IX: begin
        pm_ra = sm_q;
        state_nxt = S_SC_PT;
      end
      S_SC_PT: begin
        cx_nxt = pmx;
        cy_nxt = pmy;
        state_nxt = (d_r >= NW'(2)) ? S_SC_DF : S_PUSH;
      end
      S_SC_DF: begin
        dax_nxt = {t1x_r[CW-1], t1x_r} - {t2x_r[CW-1], t2x_r};
        day_nxt = {t1y_r[CW-1], t1y_r} - {t2y_r[CW-1], t2y_r};
        dbx_nxt = {cx_r[CW-1], cx_r} - {t2x_r[CW-1], t2x_r};
        dby_nxt = {cy_r[CW-1], cy_r} - {t2y_r[CW-1], t2y_r};
        state_nxt = S_SC_M;
      end
      S_SC_M: state_nxt = S_SC_T;
      S_SC_T: begin
        // pop a turn that is not counterclockwise
        if (tv <= 0) begin
          t1x_nxt = t2x_r;
          t1y_nxt = t2y_r;
          d_nxt   = NW'(d_r - 1'b1);
          if (d_r >= NW'(3)) begin
            hm_ra = IW'(d_r - NW'(3));
            state_nxt = S_SC_POP;
          end else begin
            state_nxt = S_PUSH;
          end
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_SC_POP: begin
        t2x_nxt = hmx;
        t2y_nxt = hmy;
        state_nxt = S_SC_DF;
      end
      S_PUSH: begin
        if (d_r < NW'(MAX_POINTS)) begin
          hm_we = 1'b1;
          t2x_nxt = t1x_r;
          t2y_nxt = t1y_r;
          t1x_nxt = cx_r;
          t1y_nxt = cy_r;
          d_nxt = NW'(d_r + 1'b1);
        end
        k_nxt = NW'(k_r + 1'b1);
        state_nxt = S_SC_RD;
      end

      // hand the stack out bottom first
      S_OUT_RD: state_nxt = S_OUT_W;
      S_OUT_W: begin
        if (ofree) begin
          ov_nxt = 1'b1;
          ox_nxt = oxz[CW-1:0];
          oy_nxt = oyz[CW-1:0];
          oe_nxt = 1'b0;
          oo_nxt = ovf_r;
          ol_nxt = (NW'(k_r + 1'b1) == d_r);
          k_nxt  = NW'(k_r + 1'b1);
          state_nxt = (NW'(k_r + 1'b1) == d_r) ? S_LOAD : S_OUT_RD;
        end
      end
      S_EMPTY: begin
        if (ofree) begin
          ov_nxt = 1'b1;
          ox_nxt = '0;
          oy_nxt = '0;
          oe_nxt = 1'b1;
          oo_nxt = ovf_r;
          ol_nxt = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    n_r <= n_nxt; i_r <= i_nxt; k_r <= k_nxt; j_r <= j_nxt; m_r <= m_nxt; d_r <= d_nxt;
    piv_r <= piv_nxt; ovf_r <= ovf_nxt;
    px_r <= px_nxt; py_r <= py_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
    t1x_r <= t1x_nxt; t1y_r <= t1y_nxt; t2x_r <= t2x_nxt; t2y_r <= t2y_nxt;
    dax_r <= dax_nxt; day_r <= day_nxt; dbx_r <= dbx_nxt; dby_r <= dby_nxt;
    d2a_r <= d2a_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt; oe_r <= oe_nxt; ol_r <= ol_nxt; oo_r <= oo_nxt;
  end

  // result ports, coordinates widened to the port
  logic [CW+15:0] oxw, oyw;
  assign oxw             = {16'b0, ox_r};
  assign oyw             = {16'b0, oy_r};
  assign out_valid       = ov_r;
  assign out_vertex_x    = oxw[15:0];
  assign out_vertex_y    = oyw[15:0];
  assign out_hull_empty  = oe_r;
  assign out_overflow    = oo_r;
  assign out_last_vertex = ol_r;

endmodule
`default_nettype wire

/* dv/cghs_checker.sv */
`timescale 1ns / 1ps
module cghs_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [15:0] in_point_x,
  input  wire logic [15:0] in_point_y,
  input  wire logic        in_last_point,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] out_vertex_x,
  input  wire logic [15:0] out_vertex_y,
  input  wire logic        out_hull_empty,
  input  wire logic        out_overflow,
  input  wire logic        out_last_vertex,
  output int               fail_count,
  output int               pending
);

  localparam int CAP = 32;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        empty;
    logic        ovf;
    logic        last;
  } vertex_t;

  vertex_t hull_q[$];
  longint  pts_x[CAP];
  longint  pts_y[CAP];
  int      npts;
  bit      dropped;

  function automatic longint cross3(int o, int a, int b);
    return (pts_x[a] - pts_x[o]) * (pts_y[b] - pts_y[o])
         - (pts_y[a] - pts_y[o]) * (pts_x[b] - pts_x[o]);
  endfunction

  function automatic longint sqdist(int o, int a);
    return (pts_x[a] - pts_x[o]) ** 2 + (pts_y[a] - pts_y[o]) ** 2;
  endfunction

  function automatic bit angle_lt(int o, int a, int b);
    longint t;
    t = cross3(o, a, b);
    if (t != 0) return t > 0;
    return sqdist(o, a) < sqdist(o, b);
  endfunction

  // pivot, polar sort without duplicates, scan, then queue the hull
  task automatic build_hull();
    int order[CAP];
    int stk[CAP];
    int piv, m, d, k;
    bit dup;
    vertex_t v;
    piv = 0;
    m = 0;
    for (int i = 1; i < npts; i++)
      if (pts_y[i] < pts_y[piv] || (pts_y[i] == pts_y[piv] && pts_x[i] < pts_x[piv]))
        piv = i;
    for (int i = 0; i < npts; i++) begin
      if (i == piv || sqdist(piv, i) == 0) continue;
      dup = 0;
      for (k = 0; k < m; k++) begin
        if (angle_lt(piv, i, order[k])) break;
        if (!angle_lt(piv, order[k], i)) begin
          dup = 1;
          break;
        end
      end
      if (dup) continue;
      for (int j = m; j > k; j--) order[j] = order[j-1];
      order[k] = i;
      m++;
    end
    if (m == 0) begin
      v = '{x: '0, y: '0, empty: 1'b1, ovf: dropped, last: 1'b1};
      hull_q.insert(hull_q.size(), v);
      return;
    end
    stk[0] = piv;
    stk[1] = order[0];
    d = 2;
    for (k = 1; k < m; k++) begin
      while (d >= 2 && cross3(stk[d-2], stk[d-1], order[k]) <= 0) d--;
      if (d < CAP) begin
        stk[d] = order[k];
        d++;
      end
    end
    for (k = 0; k < d; k++) begin
      v = '{x: 16'(pts_x[stk[k]]), y: 16'(pts_y[stk[k]]), empty: 1'b0,
            ovf: dropped, last: (k == d-1)};
      hull_q.insert(hull_q.size(), v);
    end
  endtask

  always @(posedge clk) begin
    vertex_t exp_v, got;
    if (!rst_n) begin
      npts = 0;
      dropped = 0;
      fail_count = 0;
      hull_q.delete();
    end else begin
      // accepted point request
      if (in_valid && !in_stall) begin
        if (npts < CAP) begin
          pts_x[npts] = longint'($signed(in_point_x));
          pts_y[npts] = longint'($signed(in_point_y));
          npts++;
        end else begin
          dropped = 1;
        end
        if (in_last_point) begin
          build_hull();
          npts = 0;
          dropped = 0;
        end
      end
      // accepted vertex
      if (out_valid && !out_stall) begin
        got = '{out_vertex_x, out_vertex_y, out_hull_empty, out_overflow,
                out_last_vertex};
        if (hull_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected vertex %h", got);
        end else begin
          exp_v = hull_q.pop_front();
          if (got !== exp_v) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: x %h/%h y %h/%h empty %b/%b ovf %b/%b last %b/%b",
                exp_v.x, got.x, exp_v.y, got.y, exp_v.empty, got.empty,
                exp_v.ovf, got.ovf, exp_v.last, got.last);
          end
        end
      end
    end
    pending = hull_q.size();
  end

endmodule

/* dv/tb_convex_hull_graham_scan_top.sv */
`timescale 1ns / 1ps
module tb_convex_hull_graham_scan_top;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [15:0] in_point_x = '0;
  logic [15:0] in_point_y = '0;
  logic        in_last_point = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] out_vertex_x, out_vertex_y;
  logic        out_hull_empty, out_overflow, out_last_vertex;
  int          fail_count, pending;
  int          cycles = 0;
  int          hold_off = 0;
  bit          stall_mix = 1;

  localparam int LIMIT = 3000000;

  always #5 clk = ~clk;

  convex_hull_graham_scan_top dut (.*);

  cghs_checker chk (.*);

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else if (stall_mix)
      out_stall <= ($urandom_range(0, 3) == 0);
    else
      out_stall <= 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // offer one point request, with an optional gap first; valid stays up for a follower
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic lst, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_point_x <= x;
    in_point_y <= y;
    in_last_point <= lst;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
  endtask

  // random coordinate, often from a small grid so that collinear and duplicate points appear
  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 6));
      1: return 16'($signed($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_set(int n, int gap_max);
    int mode, burst;
    mode = $urandom_range(0, 2);
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) burst = $urandom_range(1, 8);
      burst--;
      send_point(rand_coord(mode), rand_coord(mode), i == n - 1,
                 burst == 0 ? $urandom_range(0, gap_max) : 0);
    end
  endtask

  initial begin
    int sent;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // single point: empty hull
    send_point(16'h8000, 16'h7fff, 1, 0);
    // duplicates only
    send_point(16'd5, 16'd5, 0, 0);
    send_point(16'd5, 16'd5, 1, 0);
    // extremes square
    send_point(16'h7fff, 16'h7fff, 0, 0);
    send_point(16'h8000, 16'h8000, 0, 1);
    send_point(16'h7fff, 16'h8000, 0, 0);
    send_point(16'h8000, 16'h7fff, 1, 0);
    // collinear with the pivot, plus a tie on lowest y
    send_point(16'd3, 16'd3, 0, 0);
    send_point(16'd1, 16'd1, 0, 0);
    send_point(16'd2, 16'd2, 0, 0);
    send_point(16'd4, 16'd0, 0, 0);
    send_point(16'd0, 16'd0, 1, 0);
    // triangle with an interior point
    send_point(16'hfff6, 16'd0, 0, 0);
    send_point(16'd10, 16'd0, 0, 0);
    send_point(16'd0, 16'd1, 0, 0);
    send_point(16'd0, 16'd10, 1, 0);
    sent = 16;

    // store overflow: 34 points, then a further set while the receiver is held off
    // long enough that the back side blocks and the input backs up
    wait_drained();
    hold_off = 8000;
    random_set(34, 0);
    random_set(12, 0);
    sent += 46;

    // pause until everything is out, then random sets
    wait_drained();
    while (sent < 210) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 36) : $urandom_range(1, 10);
      stall_mix = ($urandom_range(0, 3) != 0);
      random_set(n, $urandom_range(0, 3));
      sent += n;
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
design/cghs_pkg.sv
design/cghs_front.sv
design/cghs_queue.sv
design/cghs_back.sv
design/convex_hull_graham_scan_top.sv
dv/cghs_checker.sv
dv/tb_convex_hull_graham_scan_top.sv
